// ===== rtl/looping_stereo_linear_resampler_assert.svh =====
// assertion macros for the looping stereo linear resampler checkers
`ifndef LOOPING_STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define LOOPING_STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define LSR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("resampler check failed");

// antecedent implies consequent in the same cycle
`define LSR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("resampler check failed");

`endif

// ===== rtl/lsr_pkg.sv =====
// shared types and constants for the looping stereo linear resampler
package lsr_pkg;

    localparam int STORE_DEPTH  = 65536;
    localparam int FRAC_BITS    = 16;
    localparam int PHASE_W      = 40;
    localparam int WIDE_W       = PHASE_W + 2;
    localparam int IDX_W        = PHASE_W - FRAC_BITS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int SAMPLE_W     = 16;
    localparam int WADDR_W      = 16;
    localparam int RATE_W       = 24;
    localparam int SPEED_W      = 16;
    localparam int SPEED_SHIFT  = 12;
    localparam int LEN_W        = 17;
    localparam int LSTART_W     = 16;
    localparam int STEP_PROD_W  = RATE_W + SPEED_W;
    localparam int STEP_W       = STEP_PROD_W - SPEED_SHIFT;
    localparam int PROD_W       = SAMPLE_W + FRAC_BITS + 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int REG_IDX_W    = CFG_ADDR_W - 2;

    localparam logic [1:0] OPC_WRITE   = 2'd0;
    localparam logic [1:0] OPC_TICK    = 2'd1;
    localparam logic [1:0] OPC_RESTART = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_RATE_STEP   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPEED       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DATA_LENGTH = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LOOP_START  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_LOOP_END    = 3'd4;

    localparam logic [RATE_W-1:0]  RATE_STEP_RESET = 24'd65536;
    localparam logic [SPEED_W-1:0] SPEED_RESET     = 16'd4096;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_TICK,
        KIND_RESTART
    } kind_t;

    typedef struct packed {
        kind_t                       kind;
        logic [WADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0]  left;
        logic signed [SAMPLE_W-1:0]  right;
    } item_t;

    typedef struct packed {
        logic [RATE_W-1:0]   rate_step;
        logic [SPEED_W-1:0]  speed;
        logic [LEN_W-1:0]    data_length;
        logic [LSTART_W-1:0] loop_start;
        logic [LEN_W-1:0]    loop_end;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ2,
        ST_MULT,
        ST_FINISH
    } back_state_t;

endpackage

// ===== rtl/lsr_front.sv =====
// input stage: accepts items, classifies the opcode and drops unused codes
module lsr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // write_address, left_in, right_in
    input  logic [1:0]            s_tuser,   // opcode
    output lsr_pkg::item_t        item,
    output logic                  item_valid,
    input  logic                  item_ready
);
    import lsr_pkg::*;

    logic   stage_valid_reg;
    logic   stage_valid_next;
    item_t  stage_item_reg;
    item_t  classified;
    logic   known;
    logic   accept;
    logic   push;

    always_comb begin
        classified.addr  = s_tdata[15:0];
        classified.left  = s_tdata[31:16];
        classified.right = s_tdata[47:32];
        known            = 1'b1;
        case (s_tuser)
            OPC_WRITE:   classified.kind = KIND_WRITE;
            OPC_TICK:    classified.kind = KIND_TICK;
            OPC_RESTART: classified.kind = KIND_RESTART;
            default: begin
                classified.kind = KIND_WRITE;
                known           = 1'b0;
            end
        endcase
    end

    assign push     = stage_valid_reg && item_ready;
    assign s_tready = !stage_valid_reg || item_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept && known) begin
            stage_valid_next = 1'b1;
        end else if (push) begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && known) begin
            stage_item_reg <= classified;
        end
    end

    assign item       = stage_item_reg;
    assign item_valid = stage_valid_reg;

endmodule

// ===== rtl/lsr_queue.sv =====
// short item queue between the front and back parts
module lsr_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  lsr_pkg::item_t push_item,
    input  logic           push_valid,
    output logic           push_ready,
    output lsr_pkg::item_t pop_item,
    output logic           pop_valid,
    input  logic           pop_ready
);
    import lsr_pkg::*;

    item_t               entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = entries[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/lsr_back.sv =====
// execution part: sample store, interpolation, phase advance and result register
module lsr_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  lsr_pkg::cfg_t  cfg,
    input  lsr_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,   // left_out, right_out
    output logic [0:0]     m_tuser    // ended
);
    import lsr_pkg::*;

    back_state_t                state_reg;
    back_state_t                state_next;
    logic [PHASE_W-1:0]         phase_reg;
    logic [2*SAMPLE_W-1:0]      mem [STORE_DEPTH];
    logic [2*SAMPLE_W-1:0]      rd_data_reg;
    logic [2*SAMPLE_W-1:0]      e1_reg;
    logic [2*SAMPLE_W-1:0]      e2;
    logic                       e1_ok_reg;
    logic                       e2_ok_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [PHASE_W-1:0]         phase_adv_reg;
    logic signed [PROD_W-1:0]   prod_l_reg;
    logic signed [PROD_W-1:0]   prod_r_reg;

    logic [IDX_W-1:0]           idx;
    logic [IDX_W:0]             idx_wide;
    logic [IDX_W:0]             idx_up_wide;
    logic [FRAC_BITS-1:0]       frac;
    logic signed [FRAC_BITS:0]  frac_s;
    logic                       at_end;
    logic                       out_free;
    logic                       in_store;

    logic                       mem_we;
    logic                       mem_re;
    logic                       mem_second;
    logic                       load_end;
    logic                       load_res;
    logic                       phase_clear;
    logic [ADDR_W-1:0]          mem_addr;

    logic [STEP_PROD_W-1:0]     step_prod;
    logic [PHASE_W:0]           phase_sum;
    logic [PHASE_W-1:0]         phase_sat;
    logic signed [SAMPLE_W:0]   diff_l;
    logic signed [SAMPLE_W:0]   diff_r;
    logic signed [SAMPLE_W-1:0] x1_l;
    logic signed [SAMPLE_W-1:0] x1_r;
    logic signed [PROD_W-1:0]   res_l;
    logic signed [PROD_W-1:0]   res_r;
    logic [WIDE_W-1:0]          adv_wide;
    logic [WIDE_W-1:0]          loop_end_ph;
    logic [WIDE_W-1:0]          loop_start_ph;
    logic [WIDE_W-1:0]          span_ph;
    logic [PHASE_W-1:0]         phase_wrapped;

    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_left_reg;
    logic [SAMPLE_W-1:0]        out_right_reg;
    logic                       out_ended_reg;

    function automatic logic entry_ok(input logic [IDX_W:0] i, input logic [LEN_W-1:0] len);
        entry_ok = (i < (IDX_W + 1)'(len)) && (i < (IDX_W + 1)'(STORE_DEPTH));
    endfunction

    assign idx         = phase_reg[PHASE_W-1:FRAC_BITS];
    assign frac        = phase_reg[FRAC_BITS-1:0];
    assign frac_s      = {1'b0, frac};
    assign idx_wide    = {1'b0, idx};
    assign idx_up_wide = idx_wide + (IDX_W + 1)'(1);
    assign at_end      = (cfg.loop_end == '0) && (idx_wide >= (IDX_W + 1)'(cfg.data_length));
    assign out_free    = !out_valid_reg || m_tready;
    assign in_store    = 32'(item.addr) < STORE_DEPTH;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid && item.kind == KIND_TICK && !at_end) begin
                    state_next = ST_READ2;
                end
            end
            ST_READ2:  state_next = ST_MULT;
            ST_MULT:   state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        item_ready  = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_second  = 1'b0;
        load_end    = 1'b0;
        load_res    = 1'b0;
        phase_clear = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (item_valid) begin
                    case (item.kind)
                        KIND_WRITE: begin
                            item_ready = 1'b1;
                            mem_we     = in_store;
                        end
                        KIND_RESTART: begin
                            item_ready  = 1'b1;
                            phase_clear = 1'b1;
                        end
                        KIND_TICK: begin
                            if (at_end) begin
                                item_ready = out_free;
                                load_end   = out_free;
                            end else begin
                                item_ready = 1'b1;
                                mem_re     = 1'b1;
                            end
                        end
                        default: item_ready = 1'b1;
                    endcase
                end
            end
            ST_READ2: begin
                mem_re     = 1'b1;
                mem_second = 1'b1;
            end
            ST_FINISH: load_res = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // single port store
    assign mem_addr = mem_we ? ADDR_W'(item.addr)
                    : (mem_second ? ADDR_W'(idx_up_wide) : ADDR_W'(idx));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= {item.right, item.left};
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // datapath
    assign step_prod = cfg.rate_step * cfg.speed;
    assign phase_sum = {1'b0, phase_reg} + (PHASE_W + 1)'(step_reg);
    assign phase_sat = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
    assign e2        = e2_ok_reg ? rd_data_reg : '0;
    assign diff_l    = {e2[SAMPLE_W-1], e2[SAMPLE_W-1:0]}
                     - {e1_reg[SAMPLE_W-1], e1_reg[SAMPLE_W-1:0]};
    assign diff_r    = {e2[2*SAMPLE_W-1], e2[2*SAMPLE_W-1:SAMPLE_W]}
                     - {e1_reg[2*SAMPLE_W-1], e1_reg[2*SAMPLE_W-1:SAMPLE_W]};

    always_ff @(posedge aclk) begin
        if (mem_re && !mem_second) begin
            e1_ok_reg <= entry_ok(idx_wide, cfg.data_length);
        end
        if (mem_second) begin
            e2_ok_reg <= entry_ok(idx_up_wide, cfg.data_length);
            step_reg  <= step_prod[STEP_PROD_W-1:SPEED_SHIFT];
        end
        if (state_reg == ST_READ2) begin
            e1_reg <= e1_ok_reg ? rd_data_reg : '0;
        end
        if (state_reg == ST_MULT) begin
            prod_l_reg    <= diff_l * frac_s;
            prod_r_reg    <= diff_r * frac_s;
            phase_adv_reg <= phase_sat;
        end
    end

    // interpolated samples
    assign x1_l  = e1_reg[SAMPLE_W-1:0];
    assign x1_r  = e1_reg[2*SAMPLE_W-1:SAMPLE_W];
    assign res_l = (prod_l_reg >>> FRAC_BITS) + PROD_W'(x1_l);
    assign res_r = (prod_r_reg >>> FRAC_BITS) + PROD_W'(x1_r);

    // loop wrap
    assign adv_wide      = WIDE_W'(phase_adv_reg);
    assign loop_end_ph   = WIDE_W'({cfg.loop_end, {FRAC_BITS{1'b0}}});
    assign loop_start_ph = WIDE_W'({cfg.loop_start, {FRAC_BITS{1'b0}}});
    assign span_ph       = WIDE_W'({cfg.loop_end - LEN_W'(cfg.loop_start), {FRAC_BITS{1'b0}}});

    always_comb begin
        phase_wrapped = phase_adv_reg;
        if (cfg.loop_end != '0 && adv_wide >= loop_end_ph) begin
            if (LEN_W'(cfg.loop_start) >= cfg.loop_end) begin
                phase_wrapped = PHASE_W'(loop_start_ph);
            end else begin
                phase_wrapped = PHASE_W'(adv_wide - span_ph);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else if (phase_clear) begin
            phase_reg <= '0;
        end else if (load_res) begin
            phase_reg <= phase_wrapped;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_end || load_res) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_end) begin
            out_left_reg  <= '0;
            out_right_reg <= '0;
            out_ended_reg <= 1'b1;
        end else if (load_res) begin
            out_left_reg  <= res_l[SAMPLE_W-1:0];
            out_right_reg <= res_r[SAMPLE_W-1:0];
            out_ended_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};
    assign m_tuser  = out_ended_reg;

endmodule

// ===== rtl/looping_stereo_linear_resampler.sv =====
// top level of the looping stereo linear resampler with its register port
// Plays a stored stereo buffer at a fractional Q.16 phase step. Input items are
// taken by a one-entry input stage into a two-entry queue, so the input side keeps
// moving while the execution part works. Write and restart items are handled in the
// idle state of the execution part; a tick item passes through ST_IDLE and ST_READ2
// (two reads of the single-port sample store), ST_MULT (multiply) and ST_FINISH
// (form the result and wrap the phase), waiting there while the result register is full.
// A tick past the end of data without a loop returns silence with ended set.
// Registers sit at byte addresses 0, 4, 8, 12 and 16; the user must write them only
// while no item is in flight, and the block itself does not enforce this.
module looping_stereo_linear_resampler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // write_address, left_in, right_in
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_out, right_out
    output logic [0:0]  m_tuser,   // ended
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsr_pkg::*;

    cfg_t                  cfg_reg;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_write;
    item_t                 front_item;
    logic                  front_valid;
    logic                  front_ready;
    item_t                 back_item;
    logic                  back_valid;
    logic                  back_ready;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rate_step   <= RATE_STEP_RESET;
            cfg_reg.speed       <= SPEED_RESET;
            cfg_reg.data_length <= '0;
            cfg_reg.loop_start  <= '0;
            cfg_reg.loop_end    <= '0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_RATE_STEP:   cfg_reg.rate_step   <= pwdata[RATE_W-1:0];
                REG_SPEED:       cfg_reg.speed       <= pwdata[SPEED_W-1:0];
                REG_DATA_LENGTH: cfg_reg.data_length <= pwdata[LEN_W-1:0];
                REG_LOOP_START:  cfg_reg.loop_start  <= pwdata[LSTART_W-1:0];
                REG_LOOP_END:    cfg_reg.loop_end    <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RATE_STEP:   prdata = CFG_DATA_W'(cfg_reg.rate_step);
            REG_SPEED:       prdata = CFG_DATA_W'(cfg_reg.speed);
            REG_DATA_LENGTH: prdata = CFG_DATA_W'(cfg_reg.data_length);
            REG_LOOP_START:  prdata = CFG_DATA_W'(cfg_reg.loop_start);
            REG_LOOP_END:    prdata = CFG_DATA_W'(cfg_reg.loop_end);
            default:         prdata = '0;
        endcase
    end

    lsr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    lsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    lsr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/lsr_checker.sv =====
// port-level checks on the result channel, bound to the top level
`include "looping_stereo_linear_resampler_assert.svh"

module lsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,   // left_out, right_out
    input logic [0:0]  m_tuser    // ended
);

    `LSR_ASSERT_NEXT(a_valid_held, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `LSR_ASSERT_NEXT(a_item_held, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))
    `LSR_ASSERT_NOW(a_ended_silent, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 32'd0)
    `LSR_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid)

endmodule

bind looping_stereo_linear_resampler lsr_checker u_lsr_checker (.*);

// ===== tb/looping_stereo_linear_resampler_test.sv =====
// self-checking testbench for the looping stereo linear resampler
import lsr_pkg::*;

localparam longint unsigned PHASE_LIMIT = (64'd1 << PHASE_W) - 64'd1;

class resampler_scoreboard;
    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        silent;
    } stereo_t;

    bit [31:0]       store [STORE_DEPTH];
    bit              written [STORE_DEPTH];
    longint unsigned phase;
    cfg_t            cfg;
    stereo_t         expected_samples [$];
    int              errors;
    int              ticks;
    int              silent_ticks;
    int              wraps;
    int              saturations;
    int              writes;

    function new();
        phase            = 0;
        cfg.rate_step    = RATE_STEP_RESET;
        cfg.speed        = SPEED_RESET;
        cfg.data_length  = '0;
        cfg.loop_start   = '0;
        cfg.loop_end     = '0;
        errors           = 0;
        ticks            = 0;
        silent_ticks     = 0;
        wraps            = 0;
        saturations      = 0;
        writes           = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            REG_RATE_STEP:   cfg.rate_step   = value[RATE_W-1:0];
            REG_SPEED:       cfg.speed       = value[SPEED_W-1:0];
            REG_DATA_LENGTH: cfg.data_length = value[LEN_W-1:0];
            REG_LOOP_START:  cfg.loop_start  = value[LSTART_W-1:0];
            REG_LOOP_END:    cfg.loop_end    = value[LEN_W-1:0];
            default: ;
        endcase
    endfunction

    function logic [15:0] lerp(logic [15:0] a, logic [15:0] b, longint frac);
        longint lo;
        longint diff;
        lo   = $signed(a);
        diff = longint'($signed(b)) - lo;
        return 16'(lo + ((diff * frac) >>> FRAC_BITS));
    endfunction

    function logic [31:0] entry(longint unsigned idx);
        if (idx >= cfg.data_length || idx >= STORE_DEPTH) return 32'd0;
        return store[idx];
    endfunction

    // first neighbour of the next tick that would be read before it was ever written
    function bit missing_neighbour(output logic [15:0] addr);
        longint unsigned idx;
        longint unsigned e;
        idx  = phase >> FRAC_BITS;
        addr = '0;
        if (cfg.loop_end == 0 && idx >= cfg.data_length) return 1'b0;
        for (int k = 0; k < 2; k++) begin
            e = idx + k;
            if (e < cfg.data_length && e < STORE_DEPTH && !written[e]) begin
                addr = e[15:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void predict_tick();
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned rate;
        longint unsigned speed;
        longint unsigned nxt;
        longint unsigned lstart;
        longint unsigned lend;
        logic [31:0]     e1;
        logic [31:0]     e2;
        stereo_t         s;
        idx    = phase >> FRAC_BITS;
        frac   = phase & ((64'd1 << FRAC_BITS) - 64'd1);
        lstart = cfg.loop_start;
        lend   = cfg.loop_end;
        ticks++;
        if (lend == 0 && idx >= cfg.data_length) begin
            s.left   = '0;
            s.right  = '0;
            s.silent = 1'b1;
            silent_ticks++;
            expected_samples.push_back(s);
            return;
        end
        e1       = entry(idx);
        e2       = entry(idx + 1);
        s.left   = lerp(e1[15:0], e2[15:0], longint'(frac));
        s.right  = lerp(e1[31:16], e2[31:16], longint'(frac));
        s.silent = 1'b0;
        rate     = cfg.rate_step;
        speed    = cfg.speed;
        nxt      = phase + ((rate * speed) >> SPEED_SHIFT);
        if (nxt > PHASE_LIMIT) begin
            nxt = PHASE_LIMIT;
            saturations++;
        end
        if (lend != 0 && nxt >= (lend << FRAC_BITS)) begin
            wraps++;
            if (lstart >= lend) nxt = lstart << FRAC_BITS;
            else nxt = nxt - ((lend - lstart) << FRAC_BITS);
        end
        phase = nxt;
        expected_samples.push_back(s);
    endfunction

    function void note_item(logic [1:0] op, logic [15:0] addr, logic [15:0] left,
                            logic [15:0] right);
        case (op)
            OPC_WRITE: begin
                store[addr]   = {right, left};
                written[addr] = 1'b1;
                writes++;
            end
            OPC_RESTART: phase = 0;
            OPC_TICK:    predict_tick();
            default: ;
        endcase
    endfunction

    task report(string what);
        errors++;
        if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task check_sample(logic [31:0] tdata, logic silent);
        stereo_t want;
        if (expected_samples.size() == 0) begin
            report($sformatf("item %h ended=%b with no sample expected", tdata, silent));
            return;
        end
        want = expected_samples.pop_front();
        if (tdata[15:0] !== want.left)
            report($sformatf("left_out %h, expected %h", tdata[15:0], want.left));
        if (tdata[31:16] !== want.right)
            report($sformatf("right_out %h, expected %h", tdata[31:16], want.right));
        if (silent !== want.silent)
            report($sformatf("ended %b, expected %b", silent, want.silent));
    endtask
endclass

module looping_stereo_linear_resampler_test;
    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_ITEMS     = 135;
    localparam logic [1:0] OPC_UNUSED = 2'd3;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_gap     = 0;
    int recv_gap     = 0;
    int cycle_count  = 0;
    int settings_run = 0;

    resampler_scoreboard sb = new();

    looping_stereo_linear_resampler dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_gap);

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn && m_tvalid && m_tready) sb.check_sample(m_tdata, m_tuser[0]);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("looping_stereo_linear_resampler_test NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] rand_level();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] with_spare_bits(logic [31:0] value, int width);
        return value | 32'($urandom << width);
    endfunction

    task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [15:0] left,
                             logic [15:0] right);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_gap) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {right, left, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(op, addr, left, right);
    endtask

    task automatic wait_for_samples();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_samples.size() != 0) @(negedge aclk);
    endtask

    task automatic settle();
        wait_for_samples();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] rate, logic [31:0] speed, logic [31:0] len,
                                 logic [31:0] lstart, logic [31:0] lend);
        settle();
        write_reg(REG_RATE_STEP, with_spare_bits(rate, RATE_W));
        write_reg(REG_SPEED, with_spare_bits(speed, SPEED_W));
        write_reg(REG_DATA_LENGTH, with_spare_bits(len, LEN_W));
        write_reg(REG_LOOP_START, with_spare_bits(lstart, LSTART_W));
        write_reg(REG_LOOP_END, with_spare_bits(lend, LEN_W));
        write_reg(REG_UNUSED, $urandom);
        settings_run++;
    endtask

    // entries a tick is about to read are written first
    task automatic tick_with_fill();
        logic [15:0] addr;
        while (sb.missing_neighbour(addr)) send_item(OPC_WRITE, addr, rand_level(), rand_level());
        send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic random_items(int count, logic [31:0] len);
        int          done;
        int          pick;
        logic [15:0] addr;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_item(OPC_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                done++;
                if (pick < 10) begin
                    send_item(OPC_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
                end else if (pick < 30) begin
                    addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, len + 1));
                    send_item(OPC_WRITE, addr, rand_level(), rand_level());
                end else if (pick < 31) begin
                    wait_for_samples();
                end else begin
                    tick_with_fill();
                end
            end
        end
    endtask

    initial begin
        logic [31:0] len;
        logic [31:0] lstart;
        repeat (10) @(negedge aclk);
        aresetn  <= 1'b1;
        send_gap = 31;
        recv_gap = 73;

        // nothing stored and no length yet: silence with ended
        send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(OPC_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OPC_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        send_item(OPC_WRITE, 16'd0, 16'h7FFF, 16'h8000);
        send_item(OPC_WRITE, 16'd1, 16'h8000, 16'h7FFF);
        send_item(OPC_WRITE, 16'd2, 16'h0000, 16'hFFFF);
        send_item(OPC_WRITE, 16'd3, 16'h7FFF, 16'h7FFF);
        send_item(OPC_WRITE, 16'd4, 16'h8000, 16'h8000);
        send_item(OPC_WRITE, 16'd5, 16'h1234, 16'hEDCC);
        send_item(OPC_WRITE, 16'd6, rand_level(), rand_level());
        send_item(OPC_WRITE, 16'd7, rand_level(), rand_level());
        send_item(OPC_WRITE, 16'hFFFF, 16'hFFFF, 16'h0000);

        // one and a half entries per tick, last neighbour past the data, then the end
        settle();
        write_reg(REG_RATE_STEP, 32'hFF01_8000);
        write_reg(REG_DATA_LENGTH, 32'hFFFE_0008);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        repeat (7) send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));

        // loop wrap
        settle();
        write_reg(REG_LOOP_START, 32'd2);
        write_reg(REG_LOOP_END, 32'd6);
        send_item(OPC_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (4) send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));

        // inverted loop
        settle();
        write_reg(REG_LOOP_START, 32'd7);
        write_reg(REG_LOOP_END, 32'd5);
        repeat (3) send_item(OPC_TICK, 16'($urandom), 16'($urandom), 16'($urandom));

        for (int s = 0; s < 9; s++) begin
            if (s == 3) begin
                send_gap = 73;
                recv_gap = 31;
            end
            if (s == 6) begin
                send_gap = 0;
                recv_gap = 0;
            end
            case (s)
                0: begin
                    len = $urandom_range(16, 48);
                    apply_setting(32'd65536, 32'd4096, len, 32'd0, 32'd0);
                end
                1: begin
                    len    = $urandom_range(8, 64);
                    lstart = $urandom_range(0, len / 2);
                    apply_setting($urandom_range(32'h4000, 32'h30000), $urandom_range(2048, 8192),
                                  len, lstart, $urandom_range(len / 2 + 1, len + 3));
                end
                2: begin
                    len = 32'd65536;
                    apply_setting(32'hFF_FFFF, 32'd0, len, 32'd65535, 32'd65536);
                end
                3: begin
                    len = $urandom_range(16, 48);
                    apply_setting(32'h8000, 32'd4096, len, 32'd4, len);
                end
                4: begin
                    len    = $urandom_range(8, 40);
                    lstart = $urandom_range(10, 60);
                    apply_setting($urandom_range(32'h8000, 32'h40000), 32'd4096, len, lstart,
                                  $urandom_range(1, lstart));
                end
                5: begin
                    len = $urandom_range(2, 20);
                    apply_setting(32'd0, 32'd65535, len, 32'd0, 32'd0);
                end
                6: begin
                    len = 32'd65536;
                    apply_setting(32'hFF_FFFF, 32'hFFFF, len, 32'd0, 32'd65536);
                end
                7: begin
                    // phase creeps up past the one-entry loop
                    len = 32'd2;
                    apply_setting(32'hFF_FFFF, 32'hFFFF, len, 32'd0, 32'd1);
                end
                default: begin
                    len = $urandom_range(1, 200);
                    apply_setting($urandom_range(0, 32'h40000), $urandom_range(0, 65535), len,
                                  $urandom_range(0, len), $urandom_range(0, len + 2));
                end
            endcase
            send_item(OPC_RESTART, 16'($urandom), 16'($urandom), 16'($urandom));
            random_items(RANDOM_ITEMS, len);
        end

        settle();
        $display("covered %0d ticks: %0d past the end, %0d loop wraps, %0d saturated phases",
                 sb.ticks, sb.silent_ticks, sb.wraps, sb.saturations);
        $display("with %0d store writes over %0d register settings and three idling profiles",
                 sb.writes, settings_run);
        if (sb.errors == 0) begin
            $display("looping_stereo_linear_resampler_test OK");
        end else begin
            $display("looping_stereo_linear_resampler_test NOT OK");
        end
        $finish;
    end
endmodule
